/* sv/assert_macros.svh */
// Assertion macros used by the audio channel mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Expression holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: %m");

// Antecedent implies consequent on the same edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");

// Antecedent implies consequent on the following edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* sv/acrm_pkg.sv */
// Package: types, codes and helper functions of the audio channel mixer.
`timescale 1ns / 1ps
`default_nettype none

package acrm_pkg;

   // Store geometry and field widths
   localparam int STORE_DEPTH = 1024;
   localparam int ELEM_W      = 16;
   localparam int ACC_W       = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // Item modes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_MIX  = 1'b1;

   typedef enum logic [2:0] {
      STATUS_MIXED   = 3'd0,
      STATUS_PASSED  = 3'd1,
      STATUS_STARVED = 3'd2,
      STATUS_LOADED  = 3'd3,
      STATUS_DROPPED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FMT_S8  = 2'd0,
      FMT_S16 = 2'd1,
      FMT_U8  = 2'd2,
      FMT_U16 = 2'd3
   } fmt_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE = 3'd0,
      CSR_FORMAT = 3'd1,
      CSR_STEREO = 3'd2,
      CSR_VOLUME = 3'd3,
      CSR_STEP   = 3'd4
   } csr_idx_type;

   // Register reset values
   localparam logic        ENABLE_RST = 1'b0;
   localparam fmt_type     FORMAT_RST = FMT_S8;
   localparam logic        STEREO_RST = 1'b0;
   localparam logic [15:0] VOLUME_RST = 16'hffff;
   localparam logic [15:0] STEP_RST   = 16'd256;

   // Channel payloads
   typedef struct packed {
      logic                    mode;
      logic [ELEM_W-1:0]       raw_element;
      logic signed [ACC_W-1:0] acc_left_in;
      logic signed [ACC_W-1:0] acc_right_in;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] acc_left_out;
      logic signed [ACC_W-1:0] acc_right_out;
      status_type              status;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_type;

   // Settings the datapath needs
   typedef struct packed {
      fmt_type     sample_format;
      logic        stereo;
      logic [15:0] volume;
   } cfg_type;

   // Item leaving the accept stage, aligned with the store read data
   typedef struct packed {
      logic                    valid;
      logic                    mixed;
      status_type              status;
      logic signed [ACC_W-1:0] acc_left;
      logic signed [ACC_W-1:0] acc_right;
   } stage_type;

   // Item after the multiply stage
   typedef struct packed {
      logic                    valid;
      logic                    mixed;
      status_type              status;
      logic signed [ACC_W-1:0] acc_left;
      logic signed [ACC_W-1:0] acc_right;
      logic signed [32:0]      prod_left;
      logic signed [32:0]      prod_right;
   } prod_stage_type;

   // Raw element to a signed 16-bit sample
   function automatic logic signed [15:0] widen(input fmt_type fmt,
                                                input logic [ELEM_W-1:0] raw);
      logic signed [15:0] s;
      unique case (fmt)
         FMT_S8:  s = {raw[7:0], 8'h00};
         FMT_S16: s = raw;
         FMT_U8:  s = {~raw[7], raw[6:0], 8'h00};
         FMT_U16: s = {~raw[15], raw[14:0]};
         default: s = raw;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

/* sv/acrm_chan_if.sv */
// Valid/ready channel interface carrying one payload per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface acrm_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/acrm_ram.sv */
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module acrm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr_a,
   input  wire logic [AW-1:0]    rd_addr_b,
   output logic      [WIDTH-1:0] rd_data_a,
   output logic      [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read ports, data held between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

/* sv/acrm_ctrl.sv */
// Accept stage: settings, ring indexes, phase, halt state and store access.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module acrm_ctrl #(
   parameter int STORE_DEPTH = acrm_pkg::STORE_DEPTH,
   localparam int IW = $clog2(STORE_DEPTH),
   localparam int CW = $clog2(STORE_DEPTH + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   acrm_chan_if.sink                     req_chan,
   acrm_chan_if.sink                     csr_chan,
   input  wire logic                     advance,
   output acrm_pkg::cfg_type             cfg,
   output acrm_pkg::stage_type           s1,
   output logic                          wr_en,
   output logic [IW-1:0]                 wr_addr,
   output logic [acrm_pkg::ELEM_W-1:0]   wr_data,
   output logic                          rd_en,
   output logic [IW-1:0]                 rd_addr_a,
   output logic [IW-1:0]                 rd_addr_b
);

   localparam int CMPW = (CW > 10) ? CW : 10;

   // Settings
   logic              enable_ff, enable_in;
   acrm_pkg::fmt_type format_ff, format_in;
   logic              stereo_ff, stereo_in;
   logic [15:0]       volume_ff, volume_in;
   logic [15:0]       step_ff, step_in;

   // Ring and phase state
   logic [IW-1:0] wr_idx_ff, wr_idx_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    frac_ff, frac_in;
   logic          halted_ff, halted_in;

   acrm_pkg::stage_type s1_ff, s1_in;

   logic                accept;
   logic                csr_write;
   logic                store_full;
   logic                starved;
   acrm_pkg::status_type status;
   logic [16:0]         phase;
   logic [9:0]          consume_raw;
   logic [CMPW-1:0]     consume_cmp;
   logic [CW-1:0]       consume_sat;
   logic [CW:0]         rd_sum;
   logic [IW:0]         wr_sum;
   logic [IW:0]         rd_next_sum;

   assign req_chan.ready = advance;
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && advance;
   assign csr_write      = csr_chan.valid;

   assign store_full = count_ff >= CW'(STORE_DEPTH);
   assign starved    = count_ff < (stereo_ff ? CW'(2) : CW'(1));

   // Item decision
   always_comb begin
      priority if (req_chan.payload.mode == acrm_pkg::MODE_LOAD) begin
         status = store_full ? acrm_pkg::STATUS_DROPPED : acrm_pkg::STATUS_LOADED;
      end else if (!enable_ff || halted_ff) begin
         status = acrm_pkg::STATUS_PASSED;
      end else if (starved) begin
         status = acrm_pkg::STATUS_STARVED;
      end else begin
         status = acrm_pkg::STATUS_MIXED;
      end
   end

   // Phase advance and elements consumed, saturated at the stored count
   always_comb begin
      phase       = {9'd0, frac_ff} + {1'b0, step_ff};
      consume_raw = stereo_ff ? {phase[16:8], 1'b0} : {1'b0, phase[16:8]};
      consume_cmp = CMPW'(consume_raw);
      consume_sat = (consume_cmp > CMPW'(count_ff)) ? count_ff : CW'(consume_cmp);
      rd_sum      = (CW + 1)'(rd_idx_ff) + (CW + 1)'(consume_sat);
      wr_sum      = (IW + 1)'(wr_idx_ff) + (IW + 1)'(1);
      rd_next_sum = (IW + 1)'(rd_idx_ff) + (IW + 1)'(1);
   end

   // Store access
   assign wr_en     = accept && (status == acrm_pkg::STATUS_LOADED);
   assign wr_addr   = wr_idx_ff;
   assign wr_data   = req_chan.payload.raw_element;
   assign rd_en     = accept && (status == acrm_pkg::STATUS_MIXED);
   assign rd_addr_a = rd_idx_ff;
   assign rd_addr_b = (rd_next_sum >= (IW + 1)'(STORE_DEPTH)) ?
                      IW'(rd_next_sum - (IW + 1)'(STORE_DEPTH)) : IW'(rd_next_sum);

   // Next state
   always_comb begin
      enable_in = enable_ff;
      format_in = format_ff;
      stereo_in = stereo_ff;
      volume_in = volume_ff;
      step_in   = step_ff;
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      frac_in   = frac_ff;
      halted_in = halted_ff;

      if (accept) begin
         unique case (status)
            acrm_pkg::STATUS_LOADED: begin
               wr_idx_in = (wr_sum >= (IW + 1)'(STORE_DEPTH)) ?
                           IW'(wr_sum - (IW + 1)'(STORE_DEPTH)) : IW'(wr_sum);
               count_in  = count_ff + CW'(1);
            end
            acrm_pkg::STATUS_MIXED: begin
               rd_idx_in = (rd_sum >= (CW + 1)'(STORE_DEPTH)) ?
                           IW'(rd_sum - (CW + 1)'(STORE_DEPTH)) : IW'(rd_sum);
               count_in  = count_ff - consume_sat;
               frac_in   = phase[7:0];
            end
            acrm_pkg::STATUS_STARVED: begin
               halted_in = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (csr_write) begin
         unique case (csr_chan.payload.index)
            acrm_pkg::CSR_ENABLE: begin
               enable_in = csr_chan.payload.data[0];
               halted_in = 1'b0;
            end
            acrm_pkg::CSR_FORMAT: format_in = acrm_pkg::fmt_type'(csr_chan.payload.data[1:0]);
            acrm_pkg::CSR_STEREO: stereo_in = csr_chan.payload.data[0];
            acrm_pkg::CSR_VOLUME: volume_in = csr_chan.payload.data;
            acrm_pkg::CSR_STEP:   step_in   = csr_chan.payload.data;
            default: begin
            end
         endcase
      end
   end

   // Item handed to the multiply stage
   always_comb begin
      s1_in.valid     = accept;
      s1_in.mixed     = status == acrm_pkg::STATUS_MIXED;
      s1_in.status    = status;
      s1_in.acc_left  = req_chan.payload.acc_left_in;
      s1_in.acc_right = req_chan.payload.acc_right_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= acrm_pkg::ENABLE_RST;
         format_ff <= acrm_pkg::FORMAT_RST;
         stereo_ff <= acrm_pkg::STEREO_RST;
         volume_ff <= acrm_pkg::VOLUME_RST;
         step_ff   <= acrm_pkg::STEP_RST;
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
         frac_ff   <= '0;
         halted_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
         format_ff <= format_in;
         stereo_ff <= stereo_in;
         volume_ff <= volume_in;
         step_ff   <= step_in;
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
         frac_ff   <= frac_in;
         halted_ff <= halted_in;
      end
   end

   // Stage register, moves only when the pipeline advances
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff <= s1_in;
      end
   end

   assign s1                = s1_ff;
   assign cfg.sample_format = format_ff;
   assign cfg.stereo        = stereo_ff;
   assign cfg.volume        = volume_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(STORE_DEPTH))
   `ASSERT_ALWAYS(a_rd_index_bound, clock, reset, rd_idx_ff <= IW'(STORE_DEPTH - 1))
   `ASSERT_ALWAYS(a_wr_index_bound, clock, reset, wr_idx_ff <= IW'(STORE_DEPTH - 1))
   `ASSERT_NEXT(a_load_counts, clock, reset, wr_en, count_ff == $past(count_ff) + CW'(1))
   `ASSERT_IMPLIES(a_halt_cause, clock, reset, $rose(halted_ff), $past(accept) && $past(status) == acrm_pkg::STATUS_STARVED)

endmodule

`default_nettype wire

/* sv/acrm_mac.sv */
// Widen, scale by volume and accumulate; output register toward the result channel.
`timescale 1ns / 1ps
`default_nettype none

module acrm_mac (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire acrm_pkg::cfg_type          cfg,
   input  wire acrm_pkg::stage_type        s1,
   input  wire logic [acrm_pkg::ELEM_W-1:0] rd_data_a,
   input  wire logic [acrm_pkg::ELEM_W-1:0] rd_data_b,
   output logic                            advance,
   acrm_chan_if.source                     rsp_chan
);

   acrm_pkg::prod_stage_type s2_ff, s2_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   acrm_pkg::rsp_type        rsp_ff, rsp_in;

   logic signed [15:0] samp_left;
   logic signed [15:0] samp_right;
   logic signed [32:0] vol_ext;
   logic signed [31:0] add_left;
   logic signed [31:0] add_right;

   // Whole pipeline moves when the output register is free or taken
   assign advance = !rsp_valid_ff || rsp_chan.ready;

   // Multiply stage
   always_comb begin
      samp_left        = acrm_pkg::widen(cfg.sample_format, rd_data_a);
      samp_right       = cfg.stereo ? acrm_pkg::widen(cfg.sample_format, rd_data_b)
                                    : samp_left;
      vol_ext          = $signed({17'd0, cfg.volume});
      s2_in.valid      = s1.valid;
      s2_in.mixed      = s1.mixed;
      s2_in.status     = s1.status;
      s2_in.acc_left   = s1.acc_left;
      s2_in.acc_right  = s1.acc_right;
      s2_in.prod_left  = 33'(samp_left) * vol_ext;
      s2_in.prod_right = 33'(samp_right) * vol_ext;
   end

   // Accumulate mixed items: floor of product over 2^16, wrapping sum; others pass through
   always_comb begin
      add_left  = {{15{s2_ff.prod_left[32]}}, s2_ff.prod_left[32:16]};
      add_right = {{15{s2_ff.prod_right[32]}}, s2_ff.prod_right[32:16]};
      rsp_valid_in         = s2_ff.valid;
      rsp_in.status        = s2_ff.status;
      rsp_in.acc_left_out  = s2_ff.mixed ? s2_ff.acc_left + add_left : s2_ff.acc_left;
      rsp_in.acc_right_out = s2_ff.mixed ? s2_ff.acc_right + add_right : s2_ff.acc_right;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_ff        <= s2_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

`default_nettype wire

/* sv/audio_channel_resample_mixer.sv */
// A result is presented once its request has passed the accept, multiply and output registers.
// Throughput: one item per cycle unless stalled, mono or stereo; both source elements
// of a stereo frame are read through the two read ports of the sample store at the
// accepting edge. A stalled result channel stops the whole three-stage pipeline.
// Reset: synchronous; settings return to their reset values, and ring indexes, phase
// and halt state clear; store contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module audio_channel_resample_mixer #(
   parameter int STORE_DEPTH = acrm_pkg::STORE_DEPTH,
   localparam int IW = $clog2(STORE_DEPTH)
) (
   input  wire logic   clock,
   input  wire logic   reset,
   acrm_chan_if.sink   req_chan,
   acrm_chan_if.source rsp_chan,
   acrm_chan_if.sink   csr_chan
);

   acrm_pkg::cfg_type   cfg;
   acrm_pkg::stage_type s1;
   logic                advance;

   logic                        wr_en;
   logic [IW-1:0]               wr_addr;
   logic [acrm_pkg::ELEM_W-1:0] wr_data;
   logic                        rd_en;
   logic [IW-1:0]               rd_addr_a;
   logic [IW-1:0]               rd_addr_b;
   logic [acrm_pkg::ELEM_W-1:0] rd_data_a;
   logic [acrm_pkg::ELEM_W-1:0] rd_data_b;

   // Accept stage and channel state
   acrm_ctrl #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_chan  (csr_chan),
      .advance   (advance),
      .cfg       (cfg),
      .s1        (s1),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b)
   );

   // Sample ring store
   acrm_ram #(
      .WIDTH (acrm_pkg::ELEM_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Scale and accumulate
   acrm_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .s1        (s1),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .advance   (advance),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
